// File: rtl/ppr_pkg.sv
// Package for the protected path rule table: codes, token type and
// controller states. No dependencies.
`default_nettype none
package ppr_pkg;

  localparam int MAX_NW = 13;   // holds lengths up to 4096
  localparam int MAX_SW = 10;   // holds slot numbers up to 1023

  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [2:0] ST_QUERIED = 3'd0;
  localparam logic [2:0] ST_ADDED   = 3'd1;
  localparam logic [2:0] ST_DUP     = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_REMOVED = 3'd4;
  localparam logic [2:0] ST_NOTFND  = 3'd5;

  typedef enum logic [2:0] {
    TK_NOP, TK_BEGIN, TK_CMP, TK_END, TK_COLLECT, TK_WR, TK_WR_END
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t           kind;
    logic [MAX_NW-1:0]   num;     // byte index, or remaining length at END
    logic [7:0]          data;
    logic [MAX_SW-1:0]   slot;    // write target
    logic                rm;      // collect also removes equal rules
    logic                hit;
    logic                found;
    logic [MAX_SW-1:0]   found_slot;
    logic                free;
    logic [MAX_SW-1:0]   free_slot;
  } tok_t;

  typedef enum logic [3:0] {
    S_IDLE, S_BEG, S_CMP, S_END, S_COL, S_WAIT, S_WR, S_WEND, S_RESP
  } ctrl_state_t;

endpackage
`default_nettype wire

// File: rtl/ppr_if.sv
// Channel interfaces of the protected path rule table.
// Depends on nothing.
`default_nettype none
interface ppr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] path_char;
  logic       last;
  modport source (output valid, command, path_char, last, input ready);
  modport sink   (input valid, command, path_char, last, output ready);
endinterface

interface ppr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       protected_res;
  logic [5:0] slot;
  modport source (output valid, status, protected_res, slot, input ready);
  modport sink   (input valid, status, protected_res, slot, output ready);
endinterface
`default_nettype wire

// File: rtl/protected_path_rule_table.sv
// Protected path rule table. Path bytes: one transaction per cycle while idle.
// After the terminating transaction, a query compares every start offset of
// the effective path against the rules, add/remove only offset zero, and an
// add that stores then writes the path into the free slot.
// Reset clears active marks and lengths at once; no clearing pass.
`default_nettype none
module protected_path_rule_table #(
  parameter int RULE_COUNT = 64,
  parameter int PATH_LEN   = 256
) (
  input  wire        clk,
  input  wire        rst_n,
  ppr_in_if.sink     in_if,
  ppr_out_if.source  out_if
);
  import ppr_pkg::*;

  tok_t chain [RULE_COUNT+1];

  ppr_ctrl #(.PATH_LEN(PATH_LEN)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
    .tok_out(chain[0]), .tok_ret(chain[RULE_COUNT])
  );

  for (genvar i = 0; i < RULE_COUNT; i++) begin : g_cell
    ppr_cell #(.PATH_LEN(PATH_LEN), .IDX(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .tok_in(chain[i]), .tok_out(chain[i+1])
    );
  end

endmodule
`default_nettype wire

// File: rtl/ppr_cell.sv
// One rule slot of the chain: rule bytes, length and active mark.
// Depends on ppr_pkg.
`default_nettype none
module ppr_cell #(
  parameter int PATH_LEN = 256,
  parameter int IDX      = 0
) (
  input  wire              clk,
  input  wire              rst_n,
  input  ppr_pkg::tok_t    tok_in,
  output ppr_pkg::tok_t    tok_out
);
  import ppr_pkg::*;

  localparam int JW = $clog2(PATH_LEN);
  localparam int LW = $clog2(PATH_LEN + 1);

  logic [7:0]    mem [PATH_LEN];
  logic [7:0]    rd_r;
  tok_t          tok_r;
  logic          valid_r, cur_ok_r, hit_r, eq_r;
  logic [LW-1:0] len_r;
  logic [LW-1:0] tnum;
  logic          me, match;

  assign tnum  = tok_r.num[LW-1:0];
  assign me    = (tok_r.slot == MAX_SW'(IDX));
  assign match = valid_r && eq_r;

  always_ff @(posedge clk) begin
    rd_r <= mem[tok_in.num[JW-1:0]];
    if (tok_r.kind == TK_WR && me) mem[tok_r.num[JW-1:0]] <= tok_r.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r    <= '0;
      valid_r  <= 1'b0;
      len_r    <= '0;
      cur_ok_r <= 1'b0;
      hit_r    <= 1'b0;
      eq_r     <= 1'b0;
    end else begin
      tok_r <= tok_in;
      case (tok_r.kind)
        TK_BEGIN: cur_ok_r <= 1'b1;
        TK_CMP: if (tnum < len_r && rd_r != tok_r.data) cur_ok_r <= 1'b0;
        TK_END: begin
          if (cur_ok_r && len_r <= tnum) hit_r <= 1'b1;
          eq_r <= cur_ok_r && (len_r == tnum);
        end
        TK_COLLECT: begin
          hit_r <= 1'b0;
          if (tok_r.rm && match) begin
            valid_r <= 1'b0;
            len_r   <= '0;
          end
        end
        TK_WR_END: if (me) begin
          valid_r <= 1'b1;
          len_r   <= tnum;
        end
        default: ;
      endcase
    end
  end

  // collect results ripple toward the lowest-priority end of the chain
  always_comb begin
    tok_out = tok_r;
    if (tok_r.kind == TK_COLLECT) begin
      tok_out.hit = tok_r.hit || (valid_r && hit_r);
      if (match && !tok_r.found) begin
        tok_out.found      = 1'b1;
        tok_out.found_slot = MAX_SW'(IDX);
      end
      if (!valid_r && !tok_r.free) begin
        tok_out.free      = 1'b1;
        tok_out.free_slot = MAX_SW'(IDX);
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/ppr_ctrl.sv
// Sequencer: buffers the path, issues tokens into the cell chain and
// builds the result. Depends on ppr_pkg and ppr_if.
`default_nettype none
module ppr_ctrl #(
  parameter int PATH_LEN = 256
) (
  input  wire              clk,
  input  wire              rst_n,
  ppr_in_if.sink           in_if,
  ppr_out_if.source        out_if,
  output ppr_pkg::tok_t    tok_out,
  input  ppr_pkg::tok_t    tok_ret
);
  import ppr_pkg::*;

  localparam int JW = $clog2(PATH_LEN);
  localparam int LW = $clog2(PATH_LEN + 1);

  logic [7:0]    path_mem [PATH_LEN];
  logic [7:0]    path_rd_r;
  logic [JW-1:0] rd_addr;

  ctrl_state_t   state_r, state_nxt;
  logic [LW-1:0] path_len_r, path_len_nxt, eff_len_r, eff_len_nxt;
  logic          zero_seen_r, zero_seen_nxt;
  logic [LW-1:0] plen_r, plen_nxt, s_r, s_nxt, j_r, j_nxt, rem;
  logic [1:0]    cmd_r, cmd_nxt;
  tok_t          tok_q_r, tok_q_nxt;
  logic [2:0]    res_st_r, res_st_nxt;
  logic          res_hit_r, res_hit_nxt;
  logic [MAX_SW-1:0] res_slot_r, res_slot_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_st_r, out_st_nxt;
  logic          out_hit_r, out_hit_nxt;
  logic [5:0]    out_slot_r, out_slot_nxt;
  logic          in_acc, wr_en;

  assign in_if.ready          = (state_r == S_IDLE);
  assign in_acc               = in_if.valid && in_if.ready;
  assign wr_en                = in_acc && !in_if.last && path_len_r < LW'(PATH_LEN);
  assign out_if.valid         = out_valid_r;
  assign out_if.status        = out_st_r;
  assign out_if.protected_res = out_hit_r;
  assign out_if.slot          = out_slot_r;
  assign rem                  = plen_r - s_r;

  always_comb begin
    tok_out      = tok_q_r;
    tok_out.data = path_rd_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) path_mem[path_len_r[JW-1:0]] <= in_if.path_char;
    path_rd_r <= path_mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    path_len_nxt  = path_len_r;
    eff_len_nxt   = eff_len_r;
    zero_seen_nxt = zero_seen_r;
    plen_nxt      = plen_r;
    s_nxt         = s_r;
    j_nxt         = j_r;
    cmd_nxt       = cmd_r;
    tok_q_nxt     = '0;
    res_st_nxt    = res_st_r;
    res_hit_nxt   = res_hit_r;
    res_slot_nxt  = res_slot_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_st_nxt    = out_st_r;
    out_hit_nxt   = out_hit_r;
    out_slot_nxt  = out_slot_r;
    rd_addr       = '0;
    tok_q_nxt.slot = res_slot_r;
    case (state_r)
      S_IDLE: if (in_acc) begin
        if (in_if.last) begin
          plen_nxt      = eff_len_r;
          cmd_nxt       = in_if.command;
          path_len_nxt  = '0;
          eff_len_nxt   = '0;
          zero_seen_nxt = 1'b0;
          s_nxt         = '0;
          state_nxt     = S_BEG;
        end else if (wr_en) begin
          path_len_nxt = path_len_r + LW'(1);
          if (in_if.path_char == 8'd0) zero_seen_nxt = 1'b1;
          else if (!zero_seen_r) eff_len_nxt = eff_len_r + LW'(1);
        end
      end
      S_BEG: begin
        tok_q_nxt.kind = TK_BEGIN;
        j_nxt          = '0;
        state_nxt      = (rem == '0) ? S_END : S_CMP;
      end
      S_CMP: begin
        tok_q_nxt.kind = TK_CMP;
        tok_q_nxt.num  = MAX_NW'(j_r);
        rd_addr        = JW'(s_r + j_r);
        j_nxt          = j_r + LW'(1);
        if (j_r + LW'(1) == rem) state_nxt = S_END;
      end
      S_END: begin
        tok_q_nxt.kind = TK_END;
        tok_q_nxt.num  = MAX_NW'(rem);
        // queries try every start offset, add and remove only offset zero
        if (cmd_r != CMD_ADD && cmd_r != CMD_REMOVE && s_r < plen_r) begin
          s_nxt     = s_r + LW'(1);
          state_nxt = S_BEG;
        end else begin
          state_nxt = S_COL;
        end
      end
      S_COL: begin
        tok_q_nxt.kind = TK_COLLECT;
        tok_q_nxt.rm   = (cmd_r == CMD_REMOVE);
        state_nxt      = S_WAIT;
      end
      S_WAIT: if (tok_ret.kind == TK_COLLECT) begin
        res_hit_nxt  = 1'b0;
        res_slot_nxt = '0;
        state_nxt    = S_RESP;
        j_nxt        = '0;
        case (cmd_r)
          CMD_ADD: begin
            if (tok_ret.found) res_st_nxt = ST_DUP;
            else if (tok_ret.free) begin
              res_st_nxt   = ST_ADDED;
              res_slot_nxt = tok_ret.free_slot;
              state_nxt    = (plen_r == '0) ? S_WEND : S_WR;
            end else res_st_nxt = ST_FULL;
          end
          CMD_REMOVE: begin
            res_st_nxt = tok_ret.found ? ST_REMOVED : ST_NOTFND;
            if (tok_ret.found) res_slot_nxt = tok_ret.found_slot;
          end
          default: begin
            res_st_nxt  = ST_QUERIED;
            res_hit_nxt = tok_ret.hit;
          end
        endcase
      end
      S_WR: begin
        tok_q_nxt.kind = TK_WR;
        tok_q_nxt.num  = MAX_NW'(j_r);
        rd_addr        = j_r[JW-1:0];
        j_nxt          = j_r + LW'(1);
        if (j_r + LW'(1) == plen_r) state_nxt = S_WEND;
      end
      S_WEND: begin
        tok_q_nxt.kind = TK_WR_END;
        tok_q_nxt.num  = MAX_NW'(plen_r);
        state_nxt      = S_RESP;
      end
      S_RESP: if (!out_valid_r || out_if.ready) begin
        out_valid_nxt = 1'b1;
        out_st_nxt    = res_st_r;
        out_hit_nxt   = res_hit_r;
        out_slot_nxt  = 6'(res_slot_r);
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      path_len_r  <= '0;
      eff_len_r   <= '0;
      zero_seen_r <= 1'b0;
      tok_q_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      path_len_r  <= path_len_nxt;
      eff_len_r   <= eff_len_nxt;
      zero_seen_r <= zero_seen_nxt;
      tok_q_r     <= tok_q_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plen_r     <= plen_nxt;
    s_r        <= s_nxt;
    j_r        <= j_nxt;
    cmd_r      <= cmd_nxt;
    res_st_r   <= res_st_nxt;
    res_hit_r  <= res_hit_nxt;
    res_slot_r <= res_slot_nxt;
    out_st_r   <= out_st_nxt;
    out_hit_r  <= out_hit_nxt;
    out_slot_r <= out_slot_nxt;
  end

  a_eff_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    eff_len_r <= path_len_r) else $error("effective length exceeds stored length");
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    path_len_r <= LW'(PATH_LEN)) else $error("path length past capacity");
  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result raised outside response state");
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT) |-> !in_if.ready) else $error("ready while walking rules");

endmodule
`default_nettype wire
